[rtl/tmbc_pkg.sv]
// ----------------------------------------------------------------------------
// Trail mask band centroid package
// Widths, limits, register indexes, sequencer states and the types shared
// between the core and its iterative divider.
// ----------------------------------------------------------------------------
package tmbc_pkg;

  localparam int PIX_W  = 8;
  localparam int COL_W  = 10;
  localparam int CFG_W  = 11;
  localparam int SUM_W  = 30;
  localparam int CNT_W  = 21;
  localparam int STEP_W = 5;

  localparam logic [CFG_W-1:0] MAX_WIDTH  = 11'd1024;
  localparam logic [CFG_W-1:0] MAX_HEIGHT = 11'd1024;
  localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [COL_W-1:0] F10_MAX    = {COL_W{1'b1}};

  // Divider pass lengths: one quotient bit per step.
  localparam logic [STEP_W-1:0] MOD_STEPS = STEP_W'(COL_W);
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(SUM_W);

  // Configuration register indexes.
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_BAND_ROWS    = 3'd1;
  localparam logic [2:0] CFG_DRY_MODE     = 3'd2;
  localparam logic [2:0] CFG_GB_MARGIN    = 3'd3;
  localparam logic [2:0] CFG_GRAY_THRESH  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Zero acts as one, anything above the limit acts as the limit.
  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

[rtl/tmbc_classify.sv]
// ----------------------------------------------------------------------------
// Trail mask band centroid pixel classifier
// Decides for one pixel whether it is background or trail.
// ----------------------------------------------------------------------------
module tmbc_classify
  import tmbc_pkg::*;
(
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  input  logic [PIX_W-1:0] gray_i,
  input  logic             dry_mode_i,
  input  logic [PIX_W-1:0] margin_i,
  input  logic [PIX_W-1:0] gray_thresh_i,
  output logic             trail_o
);

  logic [PIX_W:0] blue_plus;
  logic           vegetation;
  logic           dark;

  // The margin sum keeps its carry so that green can never pass it falsely.
  assign blue_plus  = {1'b0, blue_i} + {1'b0, margin_i};
  assign vegetation = ((green_i >= red_i) || dry_mode_i) && ({1'b0, green_i} >= blue_plus);
  assign dark       = gray_i <= gray_thresh_i;
  assign trail_o    = !(vegetation || dark);

endmodule

[rtl/tmbc_div.sv]
// ----------------------------------------------------------------------------
// Trail mask band centroid shared divider
// Restoring divider, one quotient bit per cycle, run for a chosen number of
// steps. Serves both the row modulo test and the band mean.
// ----------------------------------------------------------------------------
module tmbc_div
  import tmbc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output div_sts_t         sts_o,
  output logic [SUM_W-1:0] quotient_o,
  output logic [CNT_W-1:0] remainder_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W:0]    trial;
  logic              ge;

  // The partial remainder stays below the divisor, so no bit is lost on shift.
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
      quo_d = {quo_q[SUM_W-2:0], ge};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[rtl/trail_mask_band_centroid_core.sv]
// ----------------------------------------------------------------------------
// Trail mask band centroid core
// Classifies raster pixels as trail or background and reports the mean
// trail column of each finished horizontal band that holds trail pixels.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the s_axis channel in raster order, one transfer per
// pixel, with tuser set on the first pixel of a frame. Every pixel produces
// exactly one transfer on the m_axis channel carrying its trail flag; tuser
// there is set when that transfer also reports a finished band (its mean
// column, boundary row and band index).
// Pixel handling: a pixel outside column 0, in row 0, or with tuser set is
// taken without the divider. The first pixel of any later row makes the shared
// divider run a 10-step modulo of the row by the band height. At a band
// boundary with trail pixels the same divider runs a 30-step division of the
// position sum by the pixel count. The single divider yields one quotient bit
// per cycle, and the core takes no new pixel until it is through with the last.
// A pixel taken without the divider has its result in the output register in
// the cycle after its transfer; a row start loads its result after the modulo
// pass, the division pass when a band is reported, and ST_FIN. A stalled
// receiver keeps the result there; no further pixel is taken until it drains.
// Reset returns the configuration registers to their defaults (width 640, band
// height 48, margin 10, gray threshold 50) and clears counters and sums. The
// configuration channel is always ready; the user writes it only while idle, as the core does not enforce it.
// ----------------------------------------------------------------------------
module trail_mask_band_centroid_core
  import tmbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], gray[31:24]
  input  logic        s_axis_tuser,   // start_of_frame
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // trail_pixel[0], band_mean_x[10:1], band_row[20:11],
                                      // band_index[30:21], zero[31]
  output logic        m_axis_tuser,   // band_valid
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [10:0] cfg_data_i
);

  // Configuration registers.
  logic [CFG_W-1:0] frame_width_q;
  logic [CFG_W-1:0] band_rows_q;
  logic             dry_mode_q;
  logic [PIX_W-1:0] margin_q;
  logic [PIX_W-1:0] gray_thresh_q;

  // Frame state.
  state_e           state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] row_q, row_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] pcnt_q, pcnt_d;
  logic [COL_W-1:0] bands_q, bands_d;

  // Held pixel while the divider works.
  logic             trail_q, trail_d;
  logic             bnd_q, bnd_d;
  logic [COL_W-1:0] mean_q, mean_d;

  // Output register.
  logic             m_valid_q, m_valid_d;
  logic [31:0]      m_data_q, m_data_d;
  logic             m_user_q, m_user_d;

  logic             s_accept;
  logic             sof;
  logic             out_free;
  logic             cand;
  logic             trail_w;
  logic [CFG_W-1:0] fw_c;
  logic [CFG_W-1:0] br_c;

  div_req_t         div_req;
  div_sts_t         div_sts;
  logic [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_divisor;
  logic [SUM_W-1:0] div_quo;
  logic [CNT_W-1:0] div_rem;

  assign sof           = s_axis_tuser;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign fw_c          = clamp_cfg(frame_width_q, MAX_WIDTH);
  assign br_c          = clamp_cfg(band_rows_q, MAX_HEIGHT);

  // The first pixel of a row past row 0 may close a band; a frame start
  // clears the row, so it never does.
  assign cand = !sof && (col_q == '0) && (row_q != '0);

  tmbc_classify u_classify (
    .red_i         (s_axis_tdata[7:0]),
    .green_i       (s_axis_tdata[15:8]),
    .blue_i        (s_axis_tdata[23:16]),
    .gray_i        (s_axis_tdata[31:24]),
    .dry_mode_i    (dry_mode_q),
    .margin_i      (margin_q),
    .gray_thresh_i (gray_thresh_q),
    .trail_o       (trail_w)
  );

  tmbc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .sts_o       (div_sts),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept && cand) state_d = ST_MOD;
      end
      ST_MOD: begin
        if (div_sts.done) begin
          state_d = ((div_rem == '0) && (pcnt_q != '0)) ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_sts.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  logic             commit;
  logic             bnd_sel;
  logic             trail_sel;
  logic [COL_W-1:0] base_col, base_row, base_bands;
  logic [SUM_W-1:0] base_sum, sum_b;
  logic [CNT_W-1:0] base_cnt, cnt_b;
  logic [SUM_W:0]   sum_add;
  logic [CFG_W-1:0] col_inc, row_inc;
  logic             band_valid;
  logic [COL_W-1:0] out_mean, out_row, out_idx;

  always_comb begin
    commit       = 1'b0;
    bnd_sel      = 1'b0;
    trail_sel    = trail_w;
    base_col     = col_q;
    base_row     = row_q;
    base_sum     = sum_q;
    base_cnt     = pcnt_q;
    base_bands   = bands_q;
    trail_d      = trail_q;
    bnd_d        = bnd_q;
    mean_d       = mean_q;
    div_req      = '0;
    div_dividend = {row_q, {(SUM_W-COL_W){1'b0}}};
    div_divisor  = CNT_W'(br_c);

    case (state_q)
      ST_IDLE: begin
        if (s_accept && sof) begin
          base_col   = '0;
          base_row   = '0;
          base_sum   = '0;
          base_cnt   = '0;
          base_bands = '0;
        end
        if (s_accept) trail_d = trail_w;
        if (s_accept && cand) begin
          div_req.start = 1'b1;
          div_req.steps = MOD_STEPS;
        end
        commit = s_accept && !cand;
      end
      ST_MOD: begin
        if (div_sts.done) begin
          bnd_d = (div_rem == '0);
          if ((div_rem == '0) && (pcnt_q != '0)) begin
            div_req.start = 1'b1;
            div_req.steps = DIV_STEPS;
            div_dividend  = sum_q;
            div_divisor   = pcnt_q;
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          mean_d = (div_quo > SUM_W'(F10_MAX)) ? F10_MAX : div_quo[COL_W-1:0];
        end
      end
      ST_FIN: begin
        bnd_sel   = bnd_q;
        trail_sel = trail_q;
        commit    = out_free;
      end
      default: ;
    endcase

    // A boundary closes the band before this pixel is added to the next one.
    band_valid = bnd_sel && (base_cnt != '0);
    out_mean   = band_valid ? mean_q : '0;
    out_row    = band_valid ? base_row : '0;
    out_idx    = band_valid ? base_bands : '0;

    sum_b   = bnd_sel ? '0 : base_sum;
    cnt_b   = bnd_sel ? '0 : base_cnt;
    bands_d = (bnd_sel && (base_bands < F10_MAX)) ? base_bands + COL_W'(1) : base_bands;

    sum_add = {1'b0, sum_b} + (SUM_W+1)'(base_col);
    if (trail_sel) begin
      sum_d  = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
      pcnt_d = (cnt_b == CNT_MAX) ? cnt_b : cnt_b + CNT_W'(1);
    end else begin
      sum_d  = sum_b;
      pcnt_d = cnt_b;
    end

    col_inc = {1'b0, base_col} + CFG_W'(1);
    row_inc = {1'b0, base_row} + CFG_W'(1);
    if (col_inc >= fw_c) begin
      col_d = '0;
      row_d = (row_inc >= MAX_HEIGHT) ? '0 : row_inc[COL_W-1:0];
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = base_row;
    end

    // Output register: load on commit, drain on a completed transfer.
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (commit) begin
      m_valid_d = 1'b1;
      m_data_d  = {1'b0, out_idx, out_row, out_mean, trail_sel};
      m_user_d  = band_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      col_q         <= '0;
      row_q         <= '0;
      sum_q         <= '0;
      pcnt_q        <= '0;
      bands_q       <= '0;
      m_valid_q     <= 1'b0;
      frame_width_q <= 11'd640;
      band_rows_q   <= 11'd48;
      dry_mode_q    <= 1'b0;
      margin_q      <= 8'd10;
      gray_thresh_q <= 8'd50;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (commit) begin
        col_q   <= col_d;
        row_q   <= row_d;
        sum_q   <= sum_d;
        pcnt_q  <= pcnt_d;
        bands_q <= bands_d;
      end
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          CFG_FRAME_WIDTH: frame_width_q <= cfg_data_i;
          CFG_BAND_ROWS:   band_rows_q   <= cfg_data_i;
          CFG_DRY_MODE:    dry_mode_q    <= cfg_data_i[0];
          CFG_GB_MARGIN:   margin_q      <= cfg_data_i[PIX_W-1:0];
          CFG_GRAY_THRESH: gray_thresh_q <= cfg_data_i[PIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trail_q  <= trail_d;
    bnd_q    <= bnd_d;
    mean_q   <= mean_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The divider only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_MOD || state_q == ST_DIV))
    else $error("divider finished outside a wait state");

  // A row start past row 0 always goes through the modulo pass.
  a_row_start_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && cand) |=> (state_q == ST_MOD && div_sts.busy))
    else $error("row start did not launch the modulo pass");

  // Positions are only summed together with a counted pixel.
  a_sum_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pcnt_q == '0) |-> (sum_q == '0))
    else $error("position sum nonzero with empty band");

  // A reported band always closes at a row past row 0.
  a_band_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[20:11] != '0))
    else $error("band reported at row zero");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail mask band centroid core testbench
// Streams raster pixels into the core under random source and sink pacing.
// Every accepted pixel is run through a cycle-free software model of the
// classifier and band accumulator. Each result transfer is checked field by
// field against the oldest predicted mark.
// ----------------------------------------------------------------------------
module tb;
  import tmbc_pkg::*;

  localparam int DRAIN_CYCLES = 64;   // well past the longest modulo plus divide
  localparam int HOLD_AT      = 200;  // result count after which the sink backs off
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PIXELS  = 780;

  typedef struct packed {
    logic       sof;
    logic [7:0] gray;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic             trail;
    logic             band_valid;
    logic [COL_W-1:0] mean_x;
    logic [COL_W-1:0] band_row;
    logic [COL_W-1:0] band_idx;
  } band_mark_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16], gray[31:24]
  logic        s_axis_tuser = 1'b0; // start_of_frame
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // trail_pixel[0], band_mean_x[10:1], band_row[20:11],
                                    // band_index[30:21], zero[31]
  logic        m_axis_tuser;        // band_valid
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i = '0;
  logic [10:0] cfg_data_i = '0;

  // Register copies, as the core holds them after reset.
  logic [CFG_W-1:0] width_reg   = 11'd640;
  logic [CFG_W-1:0] bandh_reg   = 11'd48;
  logic             dry_reg     = 1'b0;
  logic [7:0]       margin_reg  = 8'd10;
  logic [7:0]       gray_th_reg = 8'd50;

  // Raster position and band accumulators of the model.
  logic [COL_W-1:0] col_pos    = '0;
  logic [COL_W-1:0] row_pos    = '0;
  logic [SUM_W-1:0] x_sum      = '0;
  logic [CNT_W-1:0] trail_cnt  = '0;
  logic [COL_W-1:0] closed_cnt = '0;

  pixel_t     pix_q[$];       // pixels waiting to be offered, head is on the bus
  band_mark_t mask_due_q[$];  // predicted marks not yet seen on the output
  int          err_cnt = 0;
  int unsigned drv_wait = 0;
  int unsigned rdy_wait = 0;
  int          rdy_seen = 0;
  bit          held = 1'b0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  trail_mask_band_centroid_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Zero behaves as one and anything past the limit as the limit.
  function automatic int unsigned fit_range(input logic [CFG_W-1:0] v,
                                            input logic [CFG_W-1:0] hi);
    if (v == '0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Classifies one accepted pixel, closes a band on a boundary row and
  // queues the mark the core has to produce for it.
  function automatic void predict_mark(input pixel_t p);
    int unsigned w;
    int unsigned h;
    int unsigned quo;
    int unsigned s;
    logic        bg;
    band_mark_t  m;
    w = fit_range(width_reg, MAX_WIDTH);
    h = fit_range(bandh_reg, MAX_HEIGHT);
    m = '0;
    if (p.sof) begin
      col_pos    = '0;
      row_pos    = '0;
      x_sum      = '0;
      trail_cnt  = '0;
      closed_cnt = '0;
    end
    bg = (((p.green >= p.red) || dry_reg) &&
          (int'(p.green) >= int'(p.blue) + int'(margin_reg))) || (p.gray <= gray_th_reg);
    m.trail = !bg;
    // The first pixel of a boundary row closes the band above it. An empty
    // band is not reported but still counts as closed.
    if (col_pos == '0 && row_pos != '0 && (row_pos % h) == 0) begin
      if (trail_cnt != '0) begin
        quo          = x_sum / trail_cnt;
        m.band_valid = 1'b1;
        m.mean_x     = (quo > F10_MAX) ? F10_MAX : COL_W'(quo);
        m.band_row   = row_pos;
        m.band_idx   = closed_cnt;
      end
      if (closed_cnt != F10_MAX) closed_cnt++;
      x_sum     = '0;
      trail_cnt = '0;
    end
    if (m.trail) begin
      s     = x_sum + col_pos;
      x_sum = (s > SUM_MAX) ? SUM_MAX : SUM_W'(s);
      if (trail_cnt != CNT_MAX) trail_cnt++;
    end
    if (col_pos + 1 >= w) begin
      col_pos = '0;
      row_pos = (row_pos + 1 >= MAX_HEIGHT) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos++;
    end
    mask_due_q.push_back(m);
  endfunction

  // Per-item wait, with long stretches of back-to-back traffic mixed in.
  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic pixel_t px(input int r, input int g, input int b, input int gy,
                                input bit sof);
    pixel_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    p.gray  = 8'(gy);
    p.sof   = sof;
    return p;
  endfunction

  // Random pixel, often placed right at one of the classifier's decision
  // edges for the register values currently programmed.
  function automatic pixel_t rand_pixel(input bit sof);
    pixel_t p;
    int     near;
    p = px($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 255), sof);
    case ($urandom_range(0, 3))
      0: begin
        near = int'(p.blue) + int'(margin_reg) - int'($urandom_range(0, 1));
        p.green = (near > 255) ? 8'd255 : ((near < 0) ? 8'd0 : 8'(near));
      end
      1: begin
        near = int'(gray_th_reg) + int'($urandom_range(0, 1));
        p.gray = (near > 255) ? 8'd255 : 8'(near);
      end
      2: p.green = p.red;
      default: ;
    endcase
    return p;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // Pixel source. The head of pix_q stays on the bus until its transfer, so
  // the queue length also covers the pixel being offered.
  always @(posedge clk_i or negedge rst_ni) begin : pixel_source
    logic offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      drv_wait      <= 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_mark(pix_q.pop_front());
        offer = 1'b0;
      end
      if (!offer) begin
        if (drv_wait != 0) begin
          drv_wait <= drv_wait - 1;
        end else if (pix_q.size() != 0) begin
          s_axis_tdata <= {pix_q[0].gray, pix_q[0].blue, pix_q[0].green, pix_q[0].red};
          s_axis_tuser <= pix_q[0].sof;
          offer = 1'b1;
          drv_wait <= draw_gap(tx_burst);
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // Result sink pacing. Once in the run, while pixels are still queued, it
  // backs off for a long stretch so that the output register fills and the
  // core stops taking pixels.
  always @(posedge clk_i or negedge rst_ni) begin : result_pace
    int unsigned n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rdy_wait      <= 0;
      rdy_seen      <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rdy_seen <= rdy_seen + 1;
      if (!held && rdy_seen >= HOLD_AT && pix_q.size() > 4) begin
        held          <= 1'b1;
        rdy_wait      <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        n = draw_gap(rx_burst);
        rdy_wait      <= n;
        m_axis_tready <= (n == 0);
      end
    end else if (rdy_wait != 0) begin
      rdy_wait      <= rdy_wait - 1;
      m_axis_tready <= (rdy_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every result transfer is matched against the oldest predicted mark.
  always @(posedge clk_i) begin : result_check
    band_mark_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mask_due_q.size() == 0) begin
        $display("%0t: result with none due, expected nothing, got tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        want = mask_due_q.pop_front();
        check_field("trail_pixel", want.trail, m_axis_tdata[0]);
        check_field("band_valid", want.band_valid, m_axis_tuser);
        check_field("band_mean_x", want.mean_x, m_axis_tdata[10:1]);
        check_field("band_row", want.band_row, m_axis_tdata[20:11]);
        check_field("band_index", want.band_idx, m_axis_tdata[30:21]);
      end
    end
  end

  // Returns once every queued pixel has been taken and answered, plus a
  // pause that covers the core's longest internal sequence.
  task automatic wait_idle();
    while (pix_q.size() != 0 || s_axis_tvalid || mask_due_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FRAME_WIDTH: width_reg   = val;
      CFG_BAND_ROWS:   bandh_reg   = val;
      CFG_DRY_MODE:    dry_reg     = val[0];
      CFG_GB_MARGIN:   margin_reg  = val[7:0];
      CFG_GRAY_THRESH: gray_th_reg = val[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [10:0] w, input logic [10:0] h, input logic dry,
                              input logic [7:0] mg, input logic [7:0] gt);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_BAND_ROWS, h);
    write_reg(CFG_DRY_MODE, {10'd0, dry});
    write_reg(CFG_GB_MARGIN, {3'd0, mg});
    write_reg(CFG_GRAY_THRESH, {3'd0, gt});
  endtask

  initial begin : stimulus
    int          n;
    int          rand_sent;
    bit          first_sof;
    logic [10:0] w;
    logic [10:0] h;
    logic [7:0]  mg;
    logic [7:0]  gt;
    rand_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frame, three columns and two-row bands. Rows 0 and 1 probe
    // the channel extremes and the exact margin and gray edges, row 2 closes
    // a populated band, rows 4 and 5 stay background so the boundary at
    // row 6 closes an empty band. A frame restart then lands mid-row.
    program_regs(11'd3, 11'd2, 1'b0, 8'd10, 8'd50);
    pix_q.push_back(px(0, 0, 0, 0, 1'b1));
    pix_q.push_back(px(255, 255, 255, 255, 1'b0));
    pix_q.push_back(px(255, 0, 0, 255, 1'b0));
    pix_q.push_back(px(0, 20, 10, 200, 1'b0));
    pix_q.push_back(px(0, 19, 10, 200, 1'b0));
    pix_q.push_back(px(100, 100, 0, 50, 1'b0));
    pix_q.push_back(px(0, 0, 0, 51, 1'b0));
    pix_q.push_back(px(10, 9, 0, 255, 1'b0));
    pix_q.push_back(px(0, 255, 0, 0, 1'b0));
    pix_q.push_back(px(200, 100, 50, 255, 1'b0));
    pix_q.push_back(px(0, 0, 255, 255, 1'b0));
    pix_q.push_back(px(255, 255, 0, 255, 1'b0));
    for (int i = 0; i < 6; i++) pix_q.push_back(px(0, 0, 0, 0, 1'b0));
    pix_q.push_back(px(128, 64, 32, 255, 1'b0));
    pix_q.push_back(px(1, 2, 3, 4, 1'b0));
    pix_q.push_back(px(77, 0, 0, 255, 1'b1));
    pix_q.push_back(px(0, 0, 0, 255, 1'b0));
    pix_q.push_back(px(0, 0, 0, 255, 1'b0));
    pix_q.push_back(px(255, 0, 0, 255, 1'b0));

    // Random phases: mostly small frames so boundaries come often, now and
    // then an out-of-range or extreme register value. A phase may continue
    // the previous frame, so a narrower width can cut a row short.
    while (rand_sent < RAND_PIXELS) begin
      n = $urandom_range(30, 110);
      case ($urandom_range(0, 9))
        0:       w = 11'd0;
        1:       w = 11'd2047;
        2:       w = 11'd1024;
        default: w = 11'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       h = 11'd0;
        1:       h = 11'd2047;
        2:       h = 11'd1024;
        default: h = 11'($urandom_range(1, 4));
      endcase
      mg = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                       : 8'($urandom_range(0, 255));
      gt = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                       : 8'($urandom_range(0, 160));
      program_regs(w, h, 1'($urandom_range(0, 1)), mg, gt);
      first_sof = 1'($urandom_range(0, 1));
      for (int i = 0; i < n; i++)
        pix_q.push_back(rand_pixel((i == 0) ? first_sof : ($urandom_range(0, 63) == 0)));
      rand_sent += n;
    end

    wait_idle();
    if (err_cnt == 0 && mask_due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
